@@ rtl/ate_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ate_pkg
// Shared widths, constants, types and the cordic step angle table of the
// accelerometer tilt estimator.
// ----------------------------------------------------------------------------
package ate_pkg;

   // field widths
   localparam int SAMPLE_W  = 16;
   localparam int ROLL_W    = 16;
   localparam int PITCH_W   = 15;
   localparam int MAG_W     = 32;
   localparam int CSR_W     = 32;
   localparam int CSR_IDX_W = 2;

   // datapath widths
   localparam int OPND_W = 17;           // atan2 operand before scaling
   localparam int XY_W   = 36;           // rotator x / y
   localparam int Z_W    = 35;           // angle accumulator, q2.30
   localparam int ANG_W  = 30;           // step angle table entry
   localparam int CNT_W  = 5;            // sequencer counter and step index
   localparam int RND_W  = 18;           // rounded angle before clamp
   localparam int ROOT_W = 16;
   localparam int REM_W  = 18;
   localparam int CAND_W = REM_W + 2;

   localparam int SCALE_SHIFT = 16;
   localparam int FRAC_DROP   = 17;

   localparam logic [CNT_W-1:0] MAG_LAST  = 5'd2;
   localparam logic [CNT_W-1:0] SQRT_LAST = 5'd15;

   localparam logic signed [Z_W-1:0]   PI_Q30      = 35'sd3373259426;
   localparam logic signed [Z_W-1:0]   ROUND_HALF  = 35'sd65536;
   localparam logic signed [RND_W-1:0] ROLL_LIMIT  = 18'sd25736;
   localparam logic signed [RND_W-1:0] PITCH_LIMIT = 18'sd12868;

   // register defaults: 64.0 and 144.0 in q16.16
   localparam logic [MAG_W-1:0] MIN_MAG_RST = 32'd4194304;
   localparam logic [MAG_W-1:0] MAX_MAG_RST = 32'd9437184;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [ROLL_W-1:0]   roll_type;
   typedef logic signed [PITCH_W-1:0]  pitch_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FULL_MODEL = 2'd0,
      CSR_MIN_MAG    = 2'd1,
      CSR_MAX_MAG    = 2'd2
   } csr_index_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_MAG,
      S_GATE,
      S_ROLL_LOAD,
      S_ROLL_RUN,
      S_ROLL_END,
      S_SQRT,
      S_PITCH_LOAD,
      S_PITCH_RUN,
      S_PITCH_END,
      S_OUT
   } state_type;

   // atan(2^-i) in q2.30, truncated
   function automatic logic [ANG_W-1:0] cordic_angle(input logic [CNT_W-1:0] idx);
      logic [ANG_W-1:0] ang;
      unique case (idx)
         5'd0:  ang = 30'd843314856;
         5'd1:  ang = 30'd497837829;
         5'd2:  ang = 30'd263043836;
         5'd3:  ang = 30'd133525158;
         5'd4:  ang = 30'd67021686;
         5'd5:  ang = 30'd33543515;
         5'd6:  ang = 30'd16775850;
         5'd7:  ang = 30'd8388437;
         5'd8:  ang = 30'd4194282;
         5'd9:  ang = 30'd2097149;
         5'd10: ang = 30'd1048575;
         5'd11: ang = 30'd524287;
         5'd12: ang = 30'd262143;
         5'd13: ang = 30'd131071;
         5'd14: ang = 30'd65535;
         5'd15: ang = 30'd32767;
         5'd16: ang = 30'd16383;
         5'd17: ang = 30'd8191;
         5'd18: ang = 30'd4095;
         5'd19: ang = 30'd2047;
         5'd20: ang = 30'd1023;
         5'd21: ang = 30'd511;
         5'd22: ang = 30'd255;
         5'd23: ang = 30'd127;
         5'd24: ang = 30'd63;
         5'd25: ang = 30'd31;
         5'd26: ang = 30'd15;
         5'd27: ang = 30'd7;
         5'd28: ang = 30'd3;
         5'd29: ang = 30'd1;
         default: ang = '0;
      endcase
      return ang;
   endfunction

endpackage

@@ rtl/ate_req_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ate_req_if
// Request channel: one imu sample with valid / ready handshake.
// ----------------------------------------------------------------------------
interface ate_req_if;
   import ate_pkg::*;

   logic       valid;
   logic       ready;
   sample_type accel_x;
   sample_type accel_y;
   sample_type accel_z;
   sample_type vel_x;
   sample_type vel_y;
   sample_type vel_z;

   modport source (
      output valid,
      output accel_x,
      output accel_y,
      output accel_z,
      output vel_x,
      output vel_y,
      output vel_z,
      input  ready
   );

   modport sink (
      input  valid,
      input  accel_x,
      input  accel_y,
      input  accel_z,
      input  vel_x,
      input  vel_y,
      input  vel_z,
      output ready
   );

endinterface

@@ rtl/ate_rsp_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ate_rsp_if
// Result channel: held attitude, held velocities and the gate flag.
// ----------------------------------------------------------------------------
interface ate_rsp_if;
   import ate_pkg::*;

   logic       valid;
   logic       ready;
   roll_type   roll_angle;
   pitch_type  pitch_angle;
   sample_type held_vx;
   sample_type held_vy;
   sample_type held_vz;
   logic       accepted;

   modport source (
      output valid,
      output roll_angle,
      output pitch_angle,
      output held_vx,
      output held_vy,
      output held_vz,
      output accepted,
      input  ready
   );

   modport sink (
      input  valid,
      input  roll_angle,
      input  pitch_angle,
      input  held_vx,
      input  held_vy,
      input  held_vz,
      input  accepted,
      output ready
   );

endinterface

@@ rtl/accel_tilt_estimator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accel_tilt_estimator
// sequence: magnitude, gate, roll pass, square root in 16 bit-steps, pitch pass,
//    result; a sample rejected at the gate goes straight to the result
// one request at a time: a new one is taken only once the previous result is
//    loaded; one shared cordic rotator runs the roll and pitch passes
// reset: synchronous; clears held attitude and velocities, loads register defaults
// ----------------------------------------------------------------------------
module accel_tilt_estimator
   import ate_pkg::*;
#(
   parameter int CORDIC_STEPS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   ate_req_if.sink              req_chan,
   ate_rsp_if.source            rsp_chan,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   localparam logic [CNT_W-1:0] STEP_LAST = CNT_W'(CORDIC_STEPS - 1);

   // configuration registers
   logic             full_model_ff, full_model_in;
   logic [MAG_W-1:0] min_mag_ff, min_mag_in;
   logic [MAG_W-1:0] max_mag_ff, max_mag_in;

   // sequencer
   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   // control strobes
   logic req_ready;
   logic req_fire;
   logic mag_step;
   logic gate_check;
   logic cordic_load;
   logic cordic_run;
   logic angle_store;
   logic pitch_pass;
   logic sqrt_start;
   logic sqrt_step;
   logic vel_store;
   logic out_load;
   logic cnt_count;
   logic cnt_last;

   // latched request
   sample_type ax_ff, ax_in, ay_ff, ay_in, az_ff, az_in;
   sample_type vx_ff, vx_in, vy_ff, vy_in, vz_ff, vz_in;

   // magnitude
   sample_type                 sq_opnd;
   logic signed [2*SAMPLE_W-1:0] sq_prod;
   logic [MAG_W-1:0]           sq_val;
   logic [MAG_W-1:0]           yz_ff, yz_in;
   logic [MAG_W-1:0]           mag_ff, mag_in;
   logic                       gate_pass;
   logic                       ok_ff, ok_in;

   // rotator
   logic signed [OPND_W-1:0] op_x, op_y, start_x, start_y;
   logic signed [Z_W-1:0]    start_z;
   logic signed [XY_W-1:0]   x_ff, x_in, y_ff, y_in, xs, ys;
   logic signed [Z_W-1:0]    z_ff, z_in, ang_z, rnd_sum, rnd_full;
   logic                     zero_ff, zero_in;
   logic signed [RND_W-1:0]  rnd_q, limit, angle;

   // square root
   logic [MAG_W-1:0]  src_ff, src_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [CAND_W-1:0] cand, trial;

   // held state
   roll_type   roll_ff, roll_in;
   pitch_type  pitch_ff, pitch_in;
   sample_type hvx_ff, hvx_in, hvy_ff, hvy_in, hvz_ff, hvz_in;

   // result register
   logic       rsp_valid_ff, rsp_valid_in;
   roll_type   rsp_roll_ff, rsp_roll_in;
   pitch_type  rsp_pitch_ff, rsp_pitch_in;
   sample_type rsp_vx_ff, rsp_vx_in, rsp_vy_ff, rsp_vy_in, rsp_vz_ff, rsp_vz_in;
   logic       rsp_ok_ff, rsp_ok_in;

   // configuration write decode
   always_comb begin
      full_model_in = full_model_ff;
      min_mag_in    = min_mag_ff;
      max_mag_in    = max_mag_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_FULL_MODEL: full_model_in = csr_wdata[0];
            CSR_MIN_MAG:    min_mag_in    = csr_wdata;
            CSR_MAX_MAG:    max_mag_in    = csr_wdata;
            default:        full_model_in = full_model_ff;
         endcase
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:       if (req_fire) state_in = S_MAG;
         S_MAG:        if (cnt_last) state_in = S_GATE;
         S_GATE:       state_in = gate_pass ? S_ROLL_LOAD : S_OUT;
         S_ROLL_LOAD:  state_in = S_ROLL_RUN;
         S_ROLL_RUN:   if (cnt_last) state_in = S_ROLL_END;
         S_ROLL_END:   state_in = S_SQRT;
         S_SQRT:       if (cnt_last) state_in = S_PITCH_LOAD;
         S_PITCH_LOAD: state_in = S_PITCH_RUN;
         S_PITCH_RUN:  if (cnt_last) state_in = S_PITCH_END;
         S_PITCH_END:  state_in = S_OUT;
         S_OUT:        if (out_load) state_in = S_IDLE;
         default:      state_in = S_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_ready   = 1'b0;
      mag_step    = 1'b0;
      gate_check  = 1'b0;
      cordic_load = 1'b0;
      cordic_run  = 1'b0;
      angle_store = 1'b0;
      pitch_pass  = 1'b0;
      sqrt_start  = 1'b0;
      sqrt_step   = 1'b0;
      vel_store   = 1'b0;
      out_load    = 1'b0;
      cnt_count   = 1'b0;
      cnt_last    = 1'b0;
      unique case (state_ff)
         S_IDLE: req_ready = 1'b1;
         S_MAG: begin
            mag_step  = 1'b1;
            cnt_count = 1'b1;
            cnt_last  = (cnt_ff == MAG_LAST);
         end
         S_GATE:      gate_check = 1'b1;
         S_ROLL_LOAD: cordic_load = 1'b1;
         S_ROLL_RUN: begin
            cordic_run = 1'b1;
            cnt_count  = 1'b1;
            cnt_last   = (cnt_ff == STEP_LAST);
         end
         S_ROLL_END: begin
            angle_store = 1'b1;
            sqrt_start  = 1'b1;
         end
         S_SQRT: begin
            sqrt_step = 1'b1;
            cnt_count = 1'b1;
            cnt_last  = (cnt_ff == SQRT_LAST);
         end
         S_PITCH_LOAD: begin
            cordic_load = 1'b1;
            pitch_pass  = 1'b1;
         end
         S_PITCH_RUN: begin
            cordic_run = 1'b1;
            pitch_pass = 1'b1;
            cnt_count  = 1'b1;
            cnt_last   = (cnt_ff == STEP_LAST);
         end
         S_PITCH_END: begin
            angle_store = 1'b1;
            pitch_pass  = 1'b1;
            vel_store   = 1'b1;
         end
         S_OUT:   out_load = !rsp_valid_ff || rsp_chan.ready;
         default: req_ready = 1'b0;
      endcase
   end

   assign req_chan.ready = req_ready;
   assign req_fire       = req_chan.valid && req_ready;

   // step counter, cleared between phases
   always_comb begin
      if (cnt_count && !cnt_last) begin
         cnt_in = cnt_ff + 1'b1;
      end else begin
         cnt_in = '0;
      end
   end

   // request latch
   always_comb begin
      ax_in = ax_ff;
      ay_in = ay_ff;
      az_in = az_ff;
      vx_in = vx_ff;
      vy_in = vy_ff;
      vz_in = vz_ff;
      if (req_fire) begin
         ax_in = req_chan.accel_x;
         ay_in = req_chan.accel_y;
         az_in = req_chan.accel_z;
         vx_in = req_chan.vel_x;
         vy_in = req_chan.vel_y;
         vz_in = req_chan.vel_z;
      end
   end

   // squared magnitude: one multiplier, ay, az, then ax
   always_comb begin
      unique case (cnt_ff)
         5'd0:    sq_opnd = ay_ff;
         5'd1:    sq_opnd = az_ff;
         default: sq_opnd = ax_ff;
      endcase
      sq_prod = sq_opnd * sq_opnd;
      sq_val  = MAG_W'(unsigned'(sq_prod));
      yz_in   = yz_ff;
      mag_in  = mag_ff;
      if (mag_step) begin
         priority if (cnt_ff == 5'd0) begin
            yz_in = sq_val;
         end else if (cnt_ff == MAG_LAST) begin
            mag_in = yz_ff + sq_val;
         end else begin
            yz_in = yz_ff + sq_val;
         end
      end
   end

   // magnitude window, both bounds inclusive
   assign gate_pass = (mag_ff >= min_mag_ff) && (mag_ff <= max_mag_ff);
   assign ok_in     = gate_check ? gate_pass : ok_ff;

   // rotator operands: roll is atan2(ay, az), pitch is atan2(-ax, root)
   always_comb begin
      if (pitch_pass) begin
         op_y = OPND_W'(0) - OPND_W'(ax_ff);
         op_x = {1'b0, root_ff};
      end else begin
         op_y = OPND_W'(ay_ff);
         op_x = OPND_W'(az_ff);
      end
      // left half plane: fold over and preload plus or minus pi
      if (op_x[OPND_W-1]) begin
         start_z = op_y[OPND_W-1] ? -PI_Q30 : PI_Q30;
         start_x = -op_x;
         start_y = -op_y;
      end else begin
         start_z = '0;
         start_x = op_x;
         start_y = op_y;
      end
   end

   // shared cordic rotator, vectoring mode
   always_comb begin
      xs      = x_ff >>> cnt_ff;
      ys      = y_ff >>> cnt_ff;
      ang_z   = signed'(Z_W'(cordic_angle(cnt_ff)));
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      zero_in = zero_ff;
      if (cordic_load) begin
         x_in    = XY_W'(start_x) <<< SCALE_SHIFT;
         y_in    = XY_W'(start_y) <<< SCALE_SHIFT;
         z_in    = start_z;
         zero_in = (op_x == '0) && (op_y == '0);
      end else if (cordic_run) begin
         if (y_ff[XY_W-1]) begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - ang_z;
         end else begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + ang_z;
         end
      end
   end

   // round to q3.13 and clamp
   always_comb begin
      rnd_sum  = z_ff + ROUND_HALF;
      rnd_full = rnd_sum >>> FRAC_DROP;
      rnd_q    = RND_W'(rnd_full);
      limit    = pitch_pass ? PITCH_LIMIT : ROLL_LIMIT;
      priority if (zero_ff) begin
         angle = '0;
      end else if (rnd_q > limit) begin
         angle = limit;
      end else if (rnd_q < -limit) begin
         angle = -limit;
      end else begin
         angle = rnd_q;
      end
   end

   // square root of ay^2+az^2, two radicand bits a step
   always_comb begin
      cand    = {rem_ff, src_ff[MAG_W-1 -: 2]};
      trial   = {2'b00, root_ff, 2'b01};
      src_in  = src_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (sqrt_start) begin
         src_in  = yz_ff;
         rem_in  = '0;
         root_in = '0;
      end else if (sqrt_step) begin
         src_in = src_ff << 2;
         if (cand >= trial) begin
            rem_in  = REM_W'(cand - trial);
            root_in = {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = REM_W'(cand);
            root_in = {root_ff[ROOT_W-2:0], 1'b0};
         end
      end
   end

   // held attitude and velocities
   always_comb begin
      roll_in  = roll_ff;
      pitch_in = pitch_ff;
      hvx_in   = hvx_ff;
      hvy_in   = hvy_ff;
      hvz_in   = hvz_ff;
      if (angle_store && !pitch_pass) begin
         roll_in = ROLL_W'(angle);
      end
      if (angle_store && pitch_pass) begin
         pitch_in = PITCH_W'(angle);
      end
      if (vel_store) begin
         hvx_in = full_model_ff ? vx_ff : '0;
         hvy_in = full_model_ff ? vy_ff : '0;
         hvz_in = full_model_ff ? vz_ff : '0;
      end
   end

   // result register
   always_comb begin
      rsp_roll_in  = rsp_roll_ff;
      rsp_pitch_in = rsp_pitch_ff;
      rsp_vx_in    = rsp_vx_ff;
      rsp_vy_in    = rsp_vy_ff;
      rsp_vz_in    = rsp_vz_ff;
      rsp_ok_in    = rsp_ok_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_roll_in  = roll_ff;
         rsp_pitch_in = pitch_ff;
         rsp_vx_in    = hvx_ff;
         rsp_vy_in    = hvy_ff;
         rsp_vz_in    = hvz_ff;
         rsp_ok_in    = ok_ff;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.roll_angle  = rsp_roll_ff;
   assign rsp_chan.pitch_angle = rsp_pitch_ff;
   assign rsp_chan.held_vx     = rsp_vx_ff;
   assign rsp_chan.held_vy     = rsp_vy_ff;
   assign rsp_chan.held_vz     = rsp_vz_ff;
   assign rsp_chan.accepted    = rsp_ok_ff;

   // control and architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         full_model_ff <= 1'b1;
         min_mag_ff    <= MIN_MAG_RST;
         max_mag_ff    <= MAX_MAG_RST;
         state_ff      <= S_IDLE;
         cnt_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
         roll_ff       <= '0;
         pitch_ff      <= '0;
         hvx_ff        <= '0;
         hvy_ff        <= '0;
         hvz_ff        <= '0;
      end else begin
         full_model_ff <= full_model_in;
         min_mag_ff    <= min_mag_in;
         max_mag_ff    <= max_mag_in;
         state_ff      <= state_in;
         cnt_ff        <= cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
         roll_ff       <= roll_in;
         pitch_ff      <= pitch_in;
         hvx_ff        <= hvx_in;
         hvy_ff        <= hvy_in;
         hvz_ff        <= hvz_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      ax_ff        <= ax_in;
      ay_ff        <= ay_in;
      az_ff        <= az_in;
      vx_ff        <= vx_in;
      vy_ff        <= vy_in;
      vz_ff        <= vz_in;
      yz_ff        <= yz_in;
      mag_ff       <= mag_in;
      ok_ff        <= ok_in;
      x_ff         <= x_in;
      y_ff         <= y_in;
      z_ff         <= z_in;
      zero_ff      <= zero_in;
      src_ff       <= src_in;
      rem_ff       <= rem_in;
      root_ff      <= root_in;
      rsp_roll_ff  <= rsp_roll_in;
      rsp_pitch_ff <= rsp_pitch_in;
      rsp_vx_ff    <= rsp_vx_in;
      rsp_vy_ff    <= rsp_vy_in;
      rsp_vz_ff    <= rsp_vz_in;
      rsp_ok_ff    <= rsp_ok_in;
   end

endmodule

@@ rtl/ate_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ate_checker
// Port-level checks of the tilt estimator, bound to the top level.
// ----------------------------------------------------------------------------
module ate_checker
   import ate_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input roll_type   rsp_roll_angle,
   input pitch_type  rsp_pitch_angle,
   input sample_type rsp_held_vx,
   input sample_type rsp_held_vy,
   input sample_type rsp_held_vz,
   input logic       rsp_accepted
);

   // held state as shown by the last delivered result
   roll_type   last_roll_ff, last_roll_in;
   pitch_type  last_pitch_ff, last_pitch_in;
   sample_type last_vx_ff, last_vx_in, last_vy_ff, last_vy_in, last_vz_ff, last_vz_in;
   logic       rsp_fire;

   assign rsp_fire = rsp_valid && rsp_ready;

   always_comb begin
      last_roll_in  = last_roll_ff;
      last_pitch_in = last_pitch_ff;
      last_vx_in    = last_vx_ff;
      last_vy_in    = last_vy_ff;
      last_vz_in    = last_vz_ff;
      if (rsp_fire) begin
         last_roll_in  = rsp_roll_angle;
         last_pitch_in = rsp_pitch_angle;
         last_vx_in    = rsp_held_vx;
         last_vy_in    = rsp_held_vy;
         last_vz_in    = rsp_held_vz;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_roll_ff  <= '0;
         last_pitch_ff <= '0;
         last_vx_ff    <= '0;
         last_vy_ff    <= '0;
         last_vz_ff    <= '0;
      end else begin
         last_roll_ff  <= last_roll_in;
         last_pitch_ff <= last_pitch_in;
         last_vx_ff    <= last_vx_in;
         last_vy_ff    <= last_vy_in;
         last_vz_ff    <= last_vz_in;
      end
   end

   // one request in flight: ready drops right after a request is taken
   a_busy_after_request: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while a previous one is still in work");

   // a stalled result stays put: valid, both angles and the gate flag
   a_result_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_roll_angle)
         && $stable(rsp_pitch_angle) && $stable(rsp_accepted))
      else $error("result changed while stalled");

   // a rejected sample leaves the held state untouched
   a_reject_keeps_state: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && !rsp_accepted |-> rsp_roll_angle == last_roll_ff
         && rsp_pitch_angle == last_pitch_ff && rsp_held_vx == last_vx_ff
         && rsp_held_vy == last_vy_ff && rsp_held_vz == last_vz_ff)
      else $error("rejected sample changed held state");

   // angles stay inside the clamp window
   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_roll_angle <= ROLL_LIMIT && rsp_roll_angle >= -ROLL_LIMIT
         && rsp_pitch_angle <= PITCH_LIMIT && rsp_pitch_angle >= -PITCH_LIMIT)
      else $error("angle outside clamp range");

endmodule

bind accel_tilt_estimator ate_checker u_ate_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_roll_angle  (rsp_chan.roll_angle),
   .rsp_pitch_angle (rsp_chan.pitch_angle),
   .rsp_held_vx     (rsp_chan.held_vx),
   .rsp_held_vy     (rsp_chan.held_vy),
   .rsp_held_vz     (rsp_chan.held_vz),
   .rsp_accepted    (rsp_chan.accepted)
);

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the accelerometer tilt estimator. Requests carry one
// imu sample; a bit-accurate cordic/isqrt predictor computes the held roll,
// pitch, velocities and gate flag, and each response is compared field by
// field. Stimulus runs directed gate and angle corners, then random traffic
// under several register settings with random stalls on both channels.
// ----------------------------------------------------------------------------
module tb;
   import ate_pkg::*;

   localparam int     CYCLE_LIMIT  = 600000;
   localparam int     DRAIN_CYCLES = 60;
   localparam int     NUM_STEPS    = 16;
   localparam longint PI_Q2_30     = 64'sd3373259426;
   localparam longint ROLL_CLAMP   = 64'sd25736;
   localparam longint PITCH_CLAMP  = 64'sd12868;
   localparam logic [31:0] MAG_64   = 32'd4194304;
   localparam logic [31:0] MAG_90   = 32'd5898240;
   localparam logic [31:0] MAG_110  = 32'd7208960;
   localparam logic [31:0] MAG_144  = 32'd9437184;
   localparam logic [31:0] MAG_FULL = 32'd3221225472;

   // atan(2^-i) in q2.30, truncated
   localparam longint ATAN_Q2_30 [0:NUM_STEPS-1] = '{
      843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
      16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
      131071, 65535, 32767
   };

   typedef struct {
      roll_type   roll;
      pitch_type  pitch;
      sample_type vx;
      sample_type vy;
      sample_type vz;
      logic       accepted;
   } tilt_result_type;

   logic              clock = 1'b0;
   logic              reset;
   logic              csr_we;
   csr_index_type     csr_index;
   logic [CSR_W-1:0]  csr_wdata;

   ate_req_if req_bus ();
   ate_rsp_if rsp_bus ();

   accel_tilt_estimator dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // predictor copy of registers and held attitude
   bit          cfg_full = 1'b1;
   logic [31:0] cfg_min  = MAG_64;
   logic [31:0] cfg_max  = MAG_144;
   longint      att_roll;
   longint      att_pitch;
   longint      att_vel [3];

   tilt_result_type tilt_expected [$];

   int  sent_count;
   int  gate_pass_count;
   int  checked_count;
   int  mismatch_count;
   int  setting_count;
   int  cycle_count;
   int  rsp_stall;
   bit  quiet_mode;

   always #5 clock = ~clock;

   // ------------------------------------------------------------------
   // predictor
   // ------------------------------------------------------------------

   function automatic longint floor_root(input longint v);
      longint rem, res, bitv;
      rem  = v;
      res  = 0;
      bitv = longint'(1) << 62;
      while (bitv > rem) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (rem >= res + bitv) begin
            rem = rem - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   // vectoring cordic: angle of (x, y), rounded to q3.13 and clamped
   function automatic longint vector_angle(input longint yin, input longint xin,
                                           input longint lim);
      longint xr, yr, zr, xs, ys, r;
      xr = xin;
      yr = yin;
      zr = 0;
      if (xr == 0 && yr == 0) return 0;
      // left half plane: fold over and start from +-pi
      if (xr < 0) begin
         zr = (yr >= 0) ? PI_Q2_30 : -PI_Q2_30;
         xr = -xr;
         yr = -yr;
      end
      xr = xr * 65536;
      yr = yr * 65536;
      for (int i = 0; i < NUM_STEPS; i++) begin
         xs = xr >>> i;
         ys = yr >>> i;
         if (yr < 0) begin
            xr = xr - ys;
            yr = yr + xs;
            zr = zr - ATAN_Q2_30[i];
         end else begin
            xr = xr + ys;
            yr = yr - xs;
            zr = zr + ATAN_Q2_30[i];
         end
      end
      r = (zr + 65536) >>> 17;
      if (r > lim) r = lim;
      if (r < -lim) r = -lim;
      return r;
   endfunction

   function automatic tilt_result_type predict_tilt(input sample_type ax, ay, az,
                                                    input sample_type vx, vy, vz);
      tilt_result_type res;
      longint yz, mag;
      bit pass;
      yz   = longint'(ay) * longint'(ay) + longint'(az) * longint'(az);
      mag  = yz + longint'(ax) * longint'(ax);
      pass = (mag >= longint'(cfg_min)) && (mag <= longint'(cfg_max));
      if (pass) begin
         att_roll   = vector_angle(longint'(ay), longint'(az), ROLL_CLAMP);
         att_pitch  = vector_angle(-longint'(ax), floor_root(yz), PITCH_CLAMP);
         att_vel[0] = cfg_full ? longint'(vx) : 0;
         att_vel[1] = cfg_full ? longint'(vy) : 0;
         att_vel[2] = cfg_full ? longint'(vz) : 0;
      end
      res.roll     = roll_type'(att_roll);
      res.pitch    = pitch_type'(att_pitch);
      res.vx       = sample_type'(att_vel[0]);
      res.vy       = sample_type'(att_vel[1]);
      res.vz       = sample_type'(att_vel[2]);
      res.accepted = pass;
      return res;
   endfunction

   // ------------------------------------------------------------------
   // channel drivers
   // ------------------------------------------------------------------

   // mostly no gap, some short, a few long
   function automatic int pick_gap();
      int r;
      if (quiet_mode) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // valid stays high after acceptance; the next call or drain decides
   task automatic send_sample(input sample_type ax, ay, az, vx, vy, vz);
      int gap;
      tilt_result_type res;
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.accel_x <= ax;
      req_bus.accel_y <= ay;
      req_bus.accel_z <= az;
      req_bus.vel_x   <= vx;
      req_bus.vel_y   <= vy;
      req_bus.vel_z   <= vz;
      do @(posedge clock); while (!req_bus.ready);
      res = predict_tilt(ax, ay, az, vx, vy, vz);
      tilt_expected.push_back(res);
      sent_count++;
      if (res.accepted) gate_pass_count++;
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      while (tilt_expected.size() != 0) @(posedge clock);
   endtask

   // write all three registers back to back once the block is idle
   task automatic program_regs(input bit fm, input logic [31:0] lo, hi);
      drain();
      csr_we    <= 1'b1;
      csr_index <= CSR_FULL_MODEL;
      csr_wdata <= {31'b0, fm};
      @(posedge clock);
      csr_index <= CSR_MIN_MAG;
      csr_wdata <= lo;
      @(posedge clock);
      csr_index <= CSR_MAX_MAG;
      csr_wdata <= hi;
      @(posedge clock);
      csr_we   <= 1'b0;
      cfg_full = fm;
      cfg_min  = lo;
      cfg_max  = hi;
      setting_count++;
   endtask

   // response ready with random stalls
   always @(posedge clock) begin
      if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
         rsp_stall = pick_gap();
      end
   end

   // ------------------------------------------------------------------
   // response checker
   // ------------------------------------------------------------------

   task automatic check_field(input string field, input logic signed [63:0] want, got);
      if (want !== got) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("mismatch on response %0d, %s: expected %0d, got %0d",
                     checked_count, field, want, got);
      end
   endtask

   always @(posedge clock) begin : result_check
      tilt_result_type want;
      if (rsp_bus.valid && rsp_bus.ready) begin
         if (tilt_expected.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("response with no request outstanding at cycle %0d", cycle_count);
         end else begin
            want = tilt_expected.pop_front();
            check_field("roll_angle", want.roll, rsp_bus.roll_angle);
            check_field("pitch_angle", want.pitch, rsp_bus.pitch_angle);
            check_field("held_vx", want.vx, rsp_bus.held_vx);
            check_field("held_vy", want.vy, rsp_bus.held_vy);
            check_field("held_vz", want.vz, rsp_bus.held_vz);
            check_field("accepted", {63'b0, want.accepted}, {63'b0, rsp_bus.accepted});
            checked_count++;
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses pending",
                  cycle_count, tilt_expected.size());
         $display("DONE: errors detected");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------

   function automatic sample_type corner_value();
      case ($urandom_range(0, 5))
         0: return 16'sd0;
         1: return -16'sd32768;
         2: return 16'sd32767;
         3: return sample_type'($urandom_range(0, 8) - 4);
         4: return -16'sd1;
         default: return sample_type'($urandom);
      endcase
   endfunction

   // rejection sampling of an acceleration inside the magnitude window
   task automatic draw_in_window(input logic [31:0] lo, hi,
                                 output sample_type ax, ay, az);
      longint span, mag;
      int     cx, cy, cz;
      span = floor_root(longint'(hi)) + 1;
      if (span > 32767) span = 32767;
      for (int t = 0; t < 64; t++) begin
         cx = int'($urandom_range(0, 2 * span)) - int'(span);
         cy = int'($urandom_range(0, 2 * span)) - int'(span);
         cz = int'($urandom_range(0, 2 * span)) - int'(span);
         mag = longint'(cx) * cx + longint'(cy) * cy + longint'(cz) * cz;
         if (mag >= longint'(lo) && mag <= longint'(hi)) break;
      end
      ax = sample_type'(cx);
      ay = sample_type'(cy);
      az = sample_type'(cz);
   endtask

   task automatic run_random_phase(input int count, input bit fm,
                                   input logic [31:0] lo, hi, input bit quiet);
      sample_type acc [3];
      sample_type vel [3];
      int pick;
      program_regs(fm, lo, hi);
      quiet_mode = quiet;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 70 && lo <= hi) begin
            draw_in_window(lo, hi, acc[0], acc[1], acc[2]);
         end else if (pick < 85) begin
            foreach (acc[k]) acc[k] = corner_value();
         end else begin
            foreach (acc[k]) acc[k] = sample_type'($urandom);
         end
         foreach (vel[k])
            vel[k] = ($urandom_range(0, 9) == 0) ? corner_value() : sample_type'($urandom);
         send_sample(acc[0], acc[1], acc[2], vel[0], vel[1], vel[2]);
      end
      quiet_mode = 1'b0;
   endtask

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------

   // zero sample right after reset: below the default window, held state is zero
   task automatic test_reset_state();
      send_sample(0, 0, 0, 16'sd32767, -16'sd32768, 16'sd1);
   endtask

   // default window edges, both bounds inclusive, and roll near +-pi
   task automatic test_gate_edges();
      program_regs(1'b1, MAG_64, MAG_144);
      send_sample(2048, 0, 0, 16'sd32767, -16'sd32768, 16'sd32767);
      send_sample(2047, 0, 0, 16'sd100, 16'sd200, 16'sd300);
      send_sample(0, 3072, 0, -16'sd32768, 16'sd32767, -16'sd32768);
      send_sample(0, 3073, 0, 16'sd5, 16'sd6, 16'sd7);
      send_sample(0, 0, -2560, 16'sd11, -16'sd12, 16'sd13);
      send_sample(0, -1, -2560, -16'sd21, 16'sd22, -16'sd23);
      send_sample(-1800, 1800, 1800, 16'sd1, 16'sd2, 16'sd3);
   endtask

   // degraded mode stores zero velocities on a pass
   task automatic test_degraded_mode();
      program_regs(1'b0, MAG_64, MAG_144);
      send_sample(0, 1800, -1800, 16'sd32767, 16'sd32767, 16'sd32767);
      send_sample(0, 0, 0, 16'sd9, 16'sd9, 16'sd9);
      send_sample(1500, -1500, 1500, -16'sd32768, 16'sd4, -16'sd4);
   endtask

   // widest window: zero vector, largest magnitude, pitch and roll extremes
   task automatic test_full_range();
      program_regs(1'b1, 32'd0, MAG_FULL);
      send_sample(0, 0, 0, 16'sd1, 16'sd1, 16'sd1);
      send_sample(-32768, -32768, -32768, 16'sd32767, 16'sd32767, 16'sd32767);
      send_sample(32767, 0, 0, -16'sd1, -16'sd1, -16'sd1);
      send_sample(-32768, 0, 0, 16'sd2, 16'sd2, 16'sd2);
      send_sample(0, 32767, 0, 16'sd3, 16'sd3, 16'sd3);
      send_sample(0, 0, -32768, 16'sd4, 16'sd4, 16'sd4);
      send_sample(0, -32768, -1, 16'sd5, 16'sd5, 16'sd5);
   endtask

   // lower bound above upper bound: nothing passes
   task automatic test_crossed_bounds();
      program_regs(1'b1, MAG_144, MAG_64);
      send_sample(0, 2500, 0, 16'sd77, 16'sd77, 16'sd77);
      send_sample(3072, 0, 0, 16'sd78, 16'sd78, 16'sd78);
      program_regs(1'b0, MAG_FULL, 32'd0);
      send_sample(0, 0, 0, 16'sd79, 16'sd79, 16'sd79);
      send_sample(-32768, -32768, -32768, 16'sd80, 16'sd80, 16'sd80);
   endtask

   task automatic test_random_traffic();
      run_random_phase(200, 1'b1, MAG_64, MAG_144, 1'b0);
      run_random_phase(150, 1'b0, 32'd0, MAG_FULL, 1'b0);
      run_random_phase(150, 1'b1, MAG_90, MAG_110, 1'b1);
      run_random_phase(100, 1'b1, 32'd0, MAG_FULL, 1'b0);
      run_random_phase(100, $urandom_range(0, 1), MAG_64, MAG_144, 1'b1);
   endtask

   task automatic finish_run();
      drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("sent %0d samples under %0d register settings, %0d passed the gate",
               sent_count, setting_count, gate_pass_count);
      $display("checked %0d responses in %0d cycles, %0d mismatches",
               checked_count, cycle_count, mismatch_count);
      if (mismatch_count == 0 && tilt_expected.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   endtask

   // ------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------

   initial begin
      reset           = 1'b1;
      csr_we          = 1'b0;
      csr_index       = CSR_FULL_MODEL;
      csr_wdata       = '0;
      req_bus.valid   = 1'b0;
      req_bus.accel_x = '0;
      req_bus.accel_y = '0;
      req_bus.accel_z = '0;
      req_bus.vel_x   = '0;
      req_bus.vel_y   = '0;
      req_bus.vel_z   = '0;
      rsp_bus.ready   = 1'b0;
      att_roll        = 0;
      att_pitch       = 0;
      foreach (att_vel[k]) att_vel[k] = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_gate_edges();
      test_degraded_mode();
      test_full_range();
      test_crossed_bounds();
      test_random_traffic();
      finish_run();
   end

endmodule

@@ accel_tilt_estimator.f @@
rtl/ate_pkg.sv
rtl/ate_req_if.sv
rtl/ate_rsp_if.sv
rtl/accel_tilt_estimator.sv
rtl/ate_checker.sv
sim/tb.sv
